[src/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the nearest palette color search block.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int KEEP_ENTRIES_DEF    = 16;
    localparam int MEMO_DEPTH          = 262144;
    localparam int MEMO_KEY_W          = $clog2(MEMO_DEPTH);
    localparam int SEARCH_END          = 255;
    localparam int DIST_W              = 18;
    localparam int KEEP_COUNT_W        = 5;
    localparam int APB_ADDR_W          = 4;
    localparam int APB_DATA_W          = 32;

    localparam logic [7:0] EMPTY_MEMO      = 8'd255;
    localparam logic [7:0] RESTRICT_BOTTOM = 8'd128;

    typedef enum logic [1:0] {
        MODE_SEARCH   = 2'd0,
        MODE_PAL_WR   = 2'd1,
        MODE_KEEP_WR  = 2'd2,
        MODE_MEMO_CLR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_RESTRICT   = 2'd0,
        REG_ALLOW      = 2'd1,
        REG_KEEP_COUNT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam t_rgb PURE_GREEN = 24'h00ff00;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0] color_index;
        logic       from_memo;
    } t_out_word;

    typedef struct packed {
        logic                  rd_en;
        logic [MEMO_KEY_W-1:0] rd_key;
        logic                  wr_en;
        logic [MEMO_KEY_W-1:0] wr_key;
        logic [7:0]            wr_data;
        logic                  clear;
    } t_memo_req;

    typedef struct packed {
        logic       en;
        logic [7:0] slot;
        t_rgb       rgb;
    } t_keep_wr;

endpackage

[src/nps_if.sv]
// ----------------------------------------------------------------------------
// nps_in_if / nps_out_if
// Valid/ready channels for query words and result words.
// ----------------------------------------------------------------------------
interface nps_in_if;
    logic              valid;
    logic              ready;
    nps_pkg::t_in_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface nps_out_if;
    logic               valid;
    logic               ready;
    nps_pkg::t_out_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[src/nps_dist.sv]
// ----------------------------------------------------------------------------
// nps_dist
// Squared Euclidean distance between a query color and a palette color.
// ----------------------------------------------------------------------------
module nps_dist (
    input  nps_pkg::t_rgb                i_a,
    input  nps_pkg::t_rgb                i_b,
    output logic [nps_pkg::DIST_W-1:0]   o_dist
);

    logic [7:0]  dr, dg, db;
    logic [15:0] sr, sg, sb;

    always_comb begin
        dr = (i_a.red   > i_b.red)   ? i_a.red   - i_b.red   : i_b.red   - i_a.red;
        dg = (i_a.green > i_b.green) ? i_a.green - i_b.green : i_b.green - i_a.green;
        db = (i_a.blue  > i_b.blue)  ? i_a.blue  - i_b.blue  : i_b.blue  - i_a.blue;
        sr = 16'(dr) * 16'(dr);
        sg = 16'(dg) * 16'(dg);
        sb = 16'(db) * 16'(db);
        o_dist = nps_pkg::DIST_W'(sr) + nps_pkg::DIST_W'(sg) + nps_pkg::DIST_W'(sb);
    end

endmodule

[src/nps_keep.sv]
// ----------------------------------------------------------------------------
// nps_keep
// Keep list of non-darkening colors, held as a row of compare cells.
// ----------------------------------------------------------------------------
module nps_keep #(
    parameter int KEEP_ENTRIES = nps_pkg::KEEP_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  nps_pkg::t_keep_wr                 i_wr,
    input  logic [nps_pkg::KEEP_COUNT_W-1:0]  i_keep_count,
    input  nps_pkg::t_rgb                     i_probe,
    output logic                              o_hit
);

    localparam int KAW = (KEEP_ENTRIES > 1) ? $clog2(KEEP_ENTRIES) : 1;

    nps_pkg::t_rgb r_entry [KEEP_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en && ({1'b0, i_wr.slot} < 9'(KEEP_ENTRIES))) begin
            r_entry[i_wr.slot[KAW-1:0]] <= i_wr.rgb;
        end
    end

    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < KEEP_ENTRIES; k++) begin
            if ((7'(k) < {2'b00, i_keep_count}) && (r_entry[k] == i_probe)) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

[src/nps_memo.sv]
// ----------------------------------------------------------------------------
// nps_memo
// Match memo keyed by the top six bits of each channel, with a clearing sweep.
// ----------------------------------------------------------------------------
module nps_memo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nps_pkg::t_memo_req  i_req,
    output logic [7:0]          o_rd_data,
    output logic                o_busy
);

    logic [7:0]                      r_mem [nps_pkg::MEMO_DEPTH];
    logic [nps_pkg::MEMO_KEY_W-1:0]  r_cnt;
    logic                            r_clearing;
    logic [nps_pkg::MEMO_KEY_W-1:0]  wr_addr;
    logic [7:0]                      wr_data;
    logic                            wr_en;

    always_comb begin
        wr_en   = r_clearing || i_req.wr_en;
        wr_addr = r_clearing ? r_cnt : i_req.wr_key;
        wr_data = r_clearing ? nps_pkg::EMPTY_MEMO : i_req.wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_key];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_cnt      <= '0;
        end else if (i_req.clear) begin
            r_clearing <= 1'b1;
            r_cnt      <= '0;
        end else if (r_clearing) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_busy = r_clearing;

`ifndef NO_ASSERTIONS
    a_no_access_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_req.rd_en && !i_req.wr_en)
        else $error("memo accessed during clearing sweep");
`endif

endmodule

[src/nearest_palette_color_search.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Maps an RGB query to the nearest palette index by squared distance, with a
// keep list of non-darkening colors and a memo of earlier answers.
//
//   channel   dir  handshake             word
//   i_query   in   valid/ready           mode, entry_index, red, green, blue
//   o_result  out  valid/ready           color_index, from_memo
//   APB       in   psel/penable, pready  restrict_colors, allow_any_color,
//                                        keep_count
//
// A memo hit is decided in S_MEMO from the registered memo read; its result
// is registered onto o_result, or held in S_HOLD while o_result is full. A
// full search walks the palette one entry per cycle through the single
// palette read port and distance unit, from the bottom index to the last.
// A memo clear, and reset, run a clearing sweep of the memo during which no
// word is accepted. A result waiting on o_result does not block the next query;
// that query's result then waits in the block, and no further word is
// accepted until it has moved to o_result.
// ----------------------------------------------------------------------------
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF,
    parameter int KEEP_ENTRIES    = nps_pkg::KEEP_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    nps_in_if.sink                           i_query,
    nps_out_if.source                        o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nps_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
    localparam int LAST   = ((PALETTE_ENTRIES < nps_pkg::SEARCH_END) ?
                             PALETTE_ENTRIES : nps_pkg::SEARCH_END) - 1;
    localparam logic [7:0] LAST_IDX = 8'(LAST);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MEMO = 4'b0010,
        S_WALK = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                                r_state, n_state;
    logic                                  r_out_valid, n_out_valid;
    nps_pkg::t_out_word                    r_out;

    logic                                  r_restrict;
    logic                                  r_allow;
    logic [nps_pkg::KEEP_COUNT_W-1:0]      r_keep_count;

    nps_pkg::t_rgb                         r_palette [PALETTE_ENTRIES];
    nps_pkg::t_rgb                         r_pal_q;

    nps_pkg::t_rgb                         r_q;
    logic [nps_pkg::MEMO_KEY_W-1:0]        r_key;
    logic                                  r_green;
    logic                                  r_restricted;
    logic [7:0]                            r_bottom;
    logic                                  r_kept;
    logic [7:0]                            r_ptr;
    logic [7:0]                            r_cur;
    logic                                  r_have;
    logic [nps_pkg::DIST_W-1:0]            r_best_val;
    logic [7:0]                            r_best_idx;
    nps_pkg::t_out_word                    r_res;

    logic                                  in_ready;
    logic                                  accept;
    logic                                  out_free;
    logic                                  cfg_wr;
    logic                                  is_search;
    nps_pkg::t_rgb                         in_rgb;
    logic                                  restricted_now;
    nps_pkg::t_rgb                         probe;
    logic                                  keep_hit;
    logic [nps_pkg::DIST_W-1:0]            cand_dist;
    logic                                  better;
    logic                                  take;
    logic                                  memo_hit;
    logic                                  finish;
    nps_pkg::t_out_word                    fin;
    logic                                  load;
    logic                                  pal_rd_en;
    logic [7:0]                            pal_rd_addr;
    nps_pkg::t_memo_req                    memo_req;
    logic [7:0]                            memo_rd;
    logic                                  memo_busy;
    nps_pkg::t_keep_wr                     keep_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            nps_pkg::REG_RESTRICT:   prdata = nps_pkg::APB_DATA_W'(r_restrict);
            nps_pkg::REG_ALLOW:      prdata = nps_pkg::APB_DATA_W'(r_allow);
            nps_pkg::REG_KEEP_COUNT: prdata = nps_pkg::APB_DATA_W'(r_keep_count);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restrict   <= 1'b0;
            r_allow      <= 1'b0;
            r_keep_count <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                nps_pkg::REG_RESTRICT:   r_restrict   <= pwdata[0];
                nps_pkg::REG_ALLOW:      r_allow      <= pwdata[0];
                nps_pkg::REG_KEEP_COUNT: r_keep_count <= pwdata[nps_pkg::KEEP_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake and decode.
    assign in_ready         = (r_state == S_IDLE) && !memo_busy;
    assign i_query.ready    = in_ready;
    assign accept           = i_query.valid && in_ready;
    assign out_free         = !r_out_valid || o_result.ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.data    = r_out;
    assign is_search        = (i_query.data.mode == nps_pkg::MODE_SEARCH);
    assign in_rgb           = '{red: i_query.data.red, green: i_query.data.green,
                                blue: i_query.data.blue};
    assign restricted_now   = r_restrict && !r_allow;

    assign keep_wr.en   = accept && (i_query.data.mode == nps_pkg::MODE_KEEP_WR);
    assign keep_wr.slot = i_query.data.entry_index;
    assign keep_wr.rgb  = in_rgb;

    assign probe = (r_state == S_MEMO) ? r_q : r_pal_q;

    nps_keep #(
        .KEEP_ENTRIES (KEEP_ENTRIES)
    ) u_keep (
        .i_clk        (i_clk),
        .i_wr         (keep_wr),
        .i_keep_count (r_keep_count),
        .i_probe      (probe),
        .o_hit        (keep_hit)
    );

    nps_dist u_dist (
        .i_a    (r_q),
        .i_b    (r_pal_q),
        .o_dist (cand_dist)
    );

    // Palette memory.
    assign pal_rd_en   = (r_state == S_MEMO) || (r_state == S_WALK);
    assign pal_rd_addr = (r_state == S_MEMO) ? r_bottom : r_ptr;

    always_ff @(posedge i_clk) begin
        if (accept && (i_query.data.mode == nps_pkg::MODE_PAL_WR) &&
            ({1'b0, i_query.data.entry_index} < 9'(PALETTE_ENTRIES))) begin
            r_palette[i_query.data.entry_index[PAL_AW-1:0]] <= in_rgb;
        end
        if (pal_rd_en) begin
            r_pal_q <= r_palette[pal_rd_addr[PAL_AW-1:0]];
        end
    end

    // Search decisions.
    assign better   = !r_have || (cand_dist < r_best_val);
    assign take     = better && (cand_dist != '0) && !r_green && !keep_hit;
    assign memo_hit = !keep_hit && (memo_rd != nps_pkg::EMPTY_MEMO) &&
                      (!r_restricted || (memo_rd >= nps_pkg::RESTRICT_BOTTOM));

    always_comb begin
        finish = 1'b0;
        fin    = '{color_index: r_best_idx, from_memo: 1'b0};
        unique case (r_state)
            S_MEMO: begin
                if (memo_hit) begin
                    finish = 1'b1;
                    fin    = '{color_index: memo_rd, from_memo: 1'b1};
                end
            end
            S_WALK: begin
                if (better && (cand_dist == '0)) begin
                    finish = 1'b1;
                    fin    = '{color_index: r_cur, from_memo: 1'b0};
                end else if (r_cur == LAST_IDX) begin
                    finish = 1'b1;
                    fin    = '{color_index: (take ? r_cur : r_best_idx), from_memo: 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign memo_req.rd_en   = accept && is_search;
    assign memo_req.rd_key  = {i_query.data.red[7:2], i_query.data.green[7:2],
                               i_query.data.blue[7:2]};
    assign memo_req.wr_en   = (r_state == S_WALK) && finish && !r_kept;
    assign memo_req.wr_key  = r_key;
    assign memo_req.wr_data = fin.color_index;
    assign memo_req.clear   = accept && (i_query.data.mode == nps_pkg::MODE_MEMO_CLR);

    nps_memo u_memo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (memo_req),
        .o_rd_data (memo_rd),
        .o_busy    (memo_busy)
    );

    // Control.
    assign load = (finish || (r_state == S_HOLD)) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_IDLE: begin
                if (accept && is_search) begin
                    n_state = S_MEMO;
                end
            end
            S_MEMO, S_WALK: begin
                if (finish) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_search) begin
            r_q          <= in_rgb;
            r_key        <= memo_req.rd_key;
            r_green      <= (in_rgb == nps_pkg::PURE_GREEN);
            r_restricted <= restricted_now;
            r_bottom     <= restricted_now ? nps_pkg::RESTRICT_BOTTOM : 8'd0;
        end
        if (r_state == S_MEMO) begin
            r_kept     <= keep_hit;
            r_ptr      <= r_bottom + 8'd1;
            r_cur      <= r_bottom;
            r_have     <= 1'b0;
            r_best_idx <= r_bottom;
        end
        if (r_state == S_WALK) begin
            r_ptr <= r_ptr + 8'd1;
            r_cur <= r_cur + 8'd1;
            if (take) begin
                r_have     <= 1'b1;
                r_best_val <= cand_dist;
                r_best_idx <= r_cur;
            end
        end
        if (finish && !out_free) begin
            r_res <= fin;
        end
        if (load) begin
            r_out <= (r_state == S_HOLD) ? r_res : fin;
        end
    end

`ifndef NO_ASSERTIONS
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cur >= r_bottom) && (r_cur <= LAST_IDX))
        else $error("walk index outside searched range");

    a_best_not_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && r_have) |-> (r_best_val != '0))
        else $error("exact match kept as running best");

    a_hold_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("result held while output register empty");

    a_clear_from_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(memo_busy) |-> $past(accept) &&
            ($past(i_query.data.mode) == nps_pkg::MODE_MEMO_CLR))
        else $error("memo sweep started without a clear word");
`endif

endmodule
